[rtl/tape_machine_executor_top_defines.svh]
// Assertion macros for the tape machine executor.
// Used by tape_machine_executor_top; no other dependencies.
`ifndef TAPE_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define TAPE_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/tme_pkg.sv]
// Shared constants for the tape machine executor: opcodes, result kinds, sizes.
// No dependencies.
package tme_pkg;

  localparam int CELL_COUNT_DEF = 65536;

  localparam logic [7:0] OP_RIGHT      = 8'h3E; // '>'
  localparam logic [7:0] OP_LEFT       = 8'h3C; // '<'
  localparam logic [7:0] OP_INC        = 8'h2B; // '+'
  localparam logic [7:0] OP_DEC        = 8'h2D; // '-'
  localparam logic [7:0] OP_READ       = 8'h2C; // ','
  localparam logic [7:0] OP_PUT_CHAR   = 8'h2E; // '.'
  localparam logic [7:0] OP_PUT_DEC    = 8'h26; // '&'
  localparam logic [7:0] OP_LOOP_OPEN  = 8'h5B; // '['
  localparam logic [7:0] OP_LOOP_CLOSE = 8'h5D; // ']'
  localparam logic [7:0] OP_MUL        = 8'h2A; // '*'
  localparam logic [7:0] OP_DIV        = 8'h2F; // '/'
  localparam logic [7:0] OP_CLEAR      = 8'h7E; // '~'
  localparam logic [7:0] OP_COPY       = 8'h5E; // '^'
  localparam logic [7:0] OP_PASTE      = 8'h76; // 'v'
  localparam logic [7:0] OP_JUMP       = 8'h40; // '@'
  localparam logic [7:0] OP_HOME       = 8'h23; // '#'

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_DEC     = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

endpackage

[rtl/tme_in_if.sv]
// Opcode request channel: valid/ready handshake with opcode and input byte.
// No dependencies.
interface tme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] in_byte;

  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink (input valid, input opcode, input in_byte, output ready);
endinterface

[rtl/tme_out_if.sv]
// Result request channel: valid/ready handshake with result kind and value.
// No dependencies.
interface tme_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_value;

  modport source (output valid, output out_kind, output out_value, input ready);
  modport sink (input valid, input out_kind, input out_value, output ready);
endinterface

[rtl/tape_machine_executor_top.sv]
// Tape machine executor: opcode sequencer around a single-port-write byte tape memory.
// Depends on tme_pkg, tme_in_if, tme_out_if and tape_machine_executor_top_defines.svh.
//
//   channel   dir   handshake             payload
//   in_ch     in    valid/ready           opcode[7:0], in_byte[7:0]
//   out_ch    out   valid/ready           out_kind[1:0], out_value[7:0]
//
// One request at a time; '*' and '/' also read the next cell, and '/' runs an 8-step
// restoring divider (skipped for a zero divisor); every cell read goes through the memory's registered read.
// After reset the tape is cleared one cell a cycle, with in_ch.ready low until every cell is clear.
// A new request is taken while the last result still waits in the output register;
// the sequencer only stalls at its final step until that result is taken.
`include "tape_machine_executor_top_defines.svh"

module tape_machine_executor_top #(
  parameter int CELL_COUNT = tme_pkg::CELL_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tme_in_if.sink    in_ch,
  tme_out_if.source out_ch
);

  localparam int PW = $clog2(CELL_COUNT);
  localparam logic [PW-1:0] LAST = PW'(CELL_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RDC, S_RDN, S_DIV, S_WRC, S_WRN, S_DONE
  } state_t;

  logic [7:0] tape_mem [CELL_COUNT];
  logic [7:0] rd_data_r;
  logic       rd_en;
  logic [PW-1:0] rd_addr;
  logic       wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0] wr_data;

  state_t        state_r, state_nxt;
  logic [PW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    clip_r, clip_nxt;
  logic [7:0]    op_r, op_nxt;
  logic [7:0]    inb_r, inb_nxt;
  logic [7:0]    cur_r, cur_nxt;
  logic [7:0]    res_r, res_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [7:0]    div_r, div_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    val_r, val_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_value_r, out_value_nxt;

  logic [PW-1:0] nidx;
  logic [7:0]    prod;
  logic [8:0]    rem_sh;
  logic [8:0]    rem_diff;

  assign nidx     = (ptr_r == LAST) ? '0 : ptr_r + PW'(1);
  assign prod     = cur_r * rd_data_r;
  assign rem_sh   = {rem_r, res_r[7]};
  assign rem_diff = rem_sh - {1'b0, div_r};

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_kind  = out_kind_r;
  assign out_ch.out_value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ptr_nxt       = ptr_r;
    clip_nxt      = clip_r;
    op_nxt        = op_r;
    inb_nxt       = inb_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = 8'h00;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + PW'(1);
        if (clr_cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          inb_nxt   = in_ch.in_byte;
          rd_en     = 1'b1;
          state_nxt = S_RDC;
        end
      end
      S_RDC: begin
        kind_nxt  = tme_pkg::KIND_NONE;
        val_nxt   = 8'h00;
        state_nxt = S_DONE;
        case (op_r)
          tme_pkg::OP_RIGHT: ptr_nxt = nidx;
          tme_pkg::OP_LEFT:  ptr_nxt = (ptr_r == '0) ? LAST : ptr_r - PW'(1);
          tme_pkg::OP_INC: begin
            wr_en   = 1'b1;
            wr_data = rd_data_r + 8'd1;
          end
          tme_pkg::OP_DEC: begin
            wr_en   = 1'b1;
            wr_data = rd_data_r - 8'd1;
          end
          tme_pkg::OP_READ: begin
            wr_en   = 1'b1;
            wr_data = inb_r;
          end
          tme_pkg::OP_PUT_CHAR: begin
            kind_nxt = tme_pkg::KIND_CHAR;
            val_nxt  = rd_data_r;
          end
          tme_pkg::OP_PUT_DEC: begin
            kind_nxt = tme_pkg::KIND_DEC;
            val_nxt  = rd_data_r;
          end
          tme_pkg::OP_LOOP_OPEN, tme_pkg::OP_LOOP_CLOSE: begin
          end
          tme_pkg::OP_MUL, tme_pkg::OP_DIV: begin
            cur_nxt   = rd_data_r;
            rd_en     = 1'b1;
            rd_addr   = nidx;
            state_nxt = S_RDN;
          end
          tme_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = 8'h00;
          end
          tme_pkg::OP_COPY:  clip_nxt = rd_data_r;
          tme_pkg::OP_PASTE: begin
            wr_en   = 1'b1;
            wr_data = clip_r;
          end
          tme_pkg::OP_JUMP: ptr_nxt = PW'(rd_data_r);
          tme_pkg::OP_HOME: ptr_nxt = '0;
          default:          kind_nxt = tme_pkg::KIND_INVALID;
        endcase
      end
      S_RDN: begin
        if (op_r == tme_pkg::OP_MUL) begin
          res_nxt   = prod;
          state_nxt = S_WRC;
        end else if (rd_data_r == 8'h00) begin
          res_nxt   = 8'h00;
          state_nxt = S_WRC;
        end else begin
          div_nxt   = rd_data_r;
          res_nxt   = cur_r;
          rem_nxt   = 8'h00;
          cnt_nxt   = 3'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, quotient shifts into res_r
        if (!rem_diff[8]) begin
          rem_nxt = rem_diff[7:0];
          res_nxt = {res_r[6:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[7:0];
          res_nxt = {res_r[6:0], 1'b0};
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = S_WRC;
        end
      end
      S_WRC: begin
        wr_en     = 1'b1;
        wr_data   = res_r;
        state_nxt = S_WRN;
      end
      S_WRN: begin
        wr_en     = 1'b1;
        wr_addr   = nidx;
        wr_data   = 8'h00;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_value_nxt = val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ptr_r       <= '0;
      clip_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ptr_r       <= ptr_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    inb_r       <= inb_nxt;
    cur_r       <= cur_nxt;
    res_r       <= res_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    cnt_r       <= cnt_nxt;
    kind_r      <= kind_nxt;
    val_r       <= val_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tape_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tape_mem[rd_addr];
    end
  end

  `TME_ASSERT_IMP(a_ptr_range, clk, rst_n, 1'b1, ptr_r <= LAST,
                  "cell pointer beyond tape")
  `TME_ASSERT_NXT(a_accept_reads, clk, rst_n, in_ch.valid && in_ch.ready,
                  state_r == S_RDC, "request not followed by cell read")
  `TME_ASSERT_IMP(a_div_rem, clk, rst_n, state_r == S_DIV, rem_r < div_r,
                  "divider remainder not below divisor")
  `TME_ASSERT_IMP(a_no_idle_write, clk, rst_n, state_r == S_IDLE || state_r == S_DONE,
                  !wr_en, "tape write outside an operation")

endmodule

[tb/tape_machine_executor_top_tb.sv]
// Testbench for tape_machine_executor_top: drives opcode requests, predicts each
// result from a tape image held here and checks every result request in order.
// Depends on tme_pkg, tme_in_if, tme_out_if and the executor RTL.
module tape_machine_executor_top_tb;
  import tme_pkg::*;

  localparam int TAPE_CELLS   = CELL_COUNT_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [7:0] KNOWN_OPS [16] = '{
    OP_RIGHT, OP_LEFT, OP_INC, OP_DEC, OP_READ, OP_PUT_CHAR, OP_PUT_DEC, OP_LOOP_OPEN,
    OP_LOOP_CLOSE, OP_MUL, OP_DIV, OP_CLEAR, OP_COPY, OP_PASTE, OP_JUMP, OP_HOME
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } tme_result_t;

  logic clk;
  logic rst_n;

  tme_in_if  in_ch();
  tme_out_if out_ch();

  tape_machine_executor_top #(.CELL_COUNT(TAPE_CELLS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Tape image and machine state
  logic [7:0]  tape_img [TAPE_CELLS];
  int unsigned cell_ptr;
  logic [7:0]  clipboard_img;

  tme_result_t expected_results [$];
  int          mismatch_count;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles_left;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tme_result_t execute_opcode(logic [7:0] op, logic [7:0] inb);
    int unsigned nxt;
    tme_result_t res;
    nxt = (cell_ptr + 1 >= TAPE_CELLS) ? 0 : cell_ptr + 1;
    res = '0;
    case (op)
      OP_RIGHT:      cell_ptr = nxt;
      OP_LEFT:       cell_ptr = (cell_ptr == 0) ? TAPE_CELLS - 1 : cell_ptr - 1;
      OP_INC:        tape_img[cell_ptr] = tape_img[cell_ptr] + 8'd1;
      OP_DEC:        tape_img[cell_ptr] = tape_img[cell_ptr] - 8'd1;
      OP_READ:       tape_img[cell_ptr] = inb;
      OP_PUT_CHAR: begin
        res.kind  = KIND_CHAR;
        res.value = tape_img[cell_ptr];
      end
      OP_PUT_DEC: begin
        res.kind  = KIND_DEC;
        res.value = tape_img[cell_ptr];
      end
      OP_LOOP_OPEN, OP_LOOP_CLOSE: ;
      OP_MUL: begin
        tape_img[cell_ptr] = tape_img[cell_ptr] * tape_img[nxt];
        tape_img[nxt] = 8'd0;
      end
      OP_DIV: begin
        tape_img[cell_ptr] = (tape_img[nxt] == 8'd0) ? 8'd0
                                                     : tape_img[cell_ptr] / tape_img[nxt];
        tape_img[nxt] = 8'd0;
      end
      OP_CLEAR:      tape_img[cell_ptr] = 8'd0;
      OP_COPY:       clipboard_img = tape_img[cell_ptr];
      OP_PASTE:      tape_img[cell_ptr] = clipboard_img;
      OP_JUMP:       cell_ptr = tape_img[cell_ptr];
      OP_HOME:       cell_ptr = 0;
      default:       res.kind = KIND_INVALID;
    endcase
    return res;
  endfunction

  // Mostly real instructions, with some raw bytes mixed in
  function automatic logic [7:0] pick_opcode();
    if ($urandom_range(99) < 90) return KNOWN_OPS[$urandom_range(15)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_request(input logic [7:0] op, input logic [7:0] inb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.in_byte <= inb;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(execute_opcode(op, inb));
  endtask

  task automatic test_directed_program();
    send_request(OP_PUT_DEC, 8'hFF);
    send_request(OP_READ, 8'hFF);
    send_request(OP_PUT_CHAR, 8'h00);
    send_request(OP_INC, 8'h00);      // wraps to zero
    send_request(OP_DEC, 8'hFF);      // wraps to 255
    send_request(OP_PUT_DEC, 8'h00);
    send_request(OP_LEFT, 8'h00);     // cell 0 to last cell
    send_request(OP_READ, 8'h07);
    send_request(OP_MUL, 8'h00);      // next cell is cell 0, product overflows
    send_request(OP_PUT_CHAR, 8'hFF);
    send_request(OP_DIV, 8'h00);      // divide by zero
    send_request(OP_PUT_DEC, 8'h00);
    send_request(OP_READ, 8'd200);
    send_request(OP_COPY, 8'h00);
    send_request(OP_RIGHT, 8'h00);    // last cell back to cell 0
    send_request(OP_PASTE, 8'h00);
    send_request(OP_JUMP, 8'h00);
    send_request(OP_HOME, 8'h00);
    send_request(OP_LOOP_OPEN, 8'hFF);
    send_request(OP_LOOP_CLOSE, 8'h00);
    send_request(OP_CLEAR, 8'h00);
    send_request(8'h00, 8'hFF);
    send_request(8'hFF, 8'h00);
    send_request(OP_PUT_CHAR, 8'h00);
  endtask

  task automatic test_random_program(input int count);
    repeat (count) send_request(pick_opcode(), 8'($urandom_range(255)));
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_result_hold_off();
    send_idle_pct = 0;
    hold_cycles_left <= HOLD_CYCLES;
    repeat (30) send_request(pick_opcode(), 8'($urandom_range(255)));
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles_left > 0) hold_cycles_left <= hold_cycles_left - 1;
    end
  end

  initial begin
    tme_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d: none expected, got kind %0d value %0d",
                     results_seen, out_ch.out_kind, out_ch.out_value);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.out_kind !== want.kind || out_ch.out_value !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result %0d: expected kind %0d value %0d, got kind %0d value %0d",
                       results_seen, want.kind, want.value,
                       out_ch.out_kind, out_ch.out_value);
          end
        end
      end
      out_ch.ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= 8'h00;
    in_ch.in_byte <= 8'h00;
    foreach (tape_img[i]) tape_img[i] = 8'd0;
    cell_ptr      = 0;
    clipboard_img = 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 79;
    test_directed_program();
    test_random_program(520);

    send_idle_pct = 79;
    recv_idle_pct = 26;
    test_random_program(520);
    test_result_hold_off();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_program(520);

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[tape_machine_executor_top.f]
+incdir+rtl
rtl/tme_pkg.sv
rtl/tme_in_if.sv
rtl/tme_out_if.sv
rtl/tape_machine_executor_top.sv
tb/tape_machine_executor_top_tb.sv
